>>> src/cbm_pkg.sv
package cbm_pkg;

   // Bank geometry
   localparam int unsigned ROM_BANK_BYTES = 16384;
   localparam int unsigned RAM_BANK_BYTES = 8192;
   localparam int unsigned ROM_OFS_BITS   = $clog2(ROM_BANK_BYTES);
   localparam int unsigned RAM_OFS_BITS   = $clog2(RAM_BANK_BYTES);

   localparam int unsigned ADDR_BITS     = 16;
   localparam int unsigned PHYS_BITS     = 21;
   localparam int unsigned ROM_BANK_BITS = 7;
   localparam int unsigned RAM_BANK_BITS = 2;

   // Access kinds
   localparam logic ACC_READ  = 1'b0;
   localparam logic ACC_WRITE = 1'b1;

   // Result targets
   localparam logic [1:0] TGT_NONE  = 2'd0;
   localparam logic [1:0] TGT_ROM   = 2'd1;
   localparam logic [1:0] TGT_RAM   = 2'd2;
   localparam logic [1:0] TGT_OTHER = 2'd3;

   // Cartridge kinds
   localparam logic [1:0] KIND_ROM_ONLY = 2'd0;
   localparam logic [1:0] KIND_MBC1     = 2'd1;
   localparam logic [1:0] KIND_MBC2     = 2'd2;

   // RAM enable key in the low nibble
   localparam logic [3:0] RAM_EN_KEY = 4'hA;

   typedef struct packed {
      logic                 req_type;
      logic [ADDR_BITS-1:0] bus_addr;
      logic [7:0]           wr_byte;
   } req_type_type;

   typedef struct packed {
      logic [1:0]               target;
      logic [PHYS_BITS-1:0]     phys_addr;
      logic                     is_store;
      logic [ROM_BANK_BITS-1:0] rom_bank_now;
   } rsp_type;

endpackage

>>> src/cbm_in_stage.sv
module cbm_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cbm_pkg::req_type_type req_data,
   output logic                  item_valid,
   input  logic                  item_take,
   output cbm_pkg::req_type_type item_data
);

   logic                  valid_ff;
   logic                  valid_in;
   cbm_pkg::req_type_type data_ff;

   // Take a new beat when empty or when the held beat moves on this cycle
   assign req_ready = !valid_ff || item_take;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until replaced
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

>>> src/cbm_translate.sv
module cbm_translate (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_wdata,
   input  logic                  item_take,
   input  cbm_pkg::req_type_type item_data,
   output cbm_pkg::rsp_type      rsp_next
);

   logic [1:0]                        cart_kind_ff;
   logic [cbm_pkg::ROM_BANK_BITS-1:0] rom_bank_ff;
   logic [cbm_pkg::ROM_BANK_BITS-1:0] rom_bank_in;
   logic [cbm_pkg::RAM_BANK_BITS-1:0] ram_bank_ff;
   logic [cbm_pkg::RAM_BANK_BITS-1:0] ram_bank_in;
   logic                              ram_en_ff;
   logic                              ram_en_in;
   logic                              rom_mode_ff;
   logic                              rom_mode_in;

   logic                              is_wr;
   logic [cbm_pkg::ADDR_BITS-1:0]     addr;
   logic [7:0]                        data;
   logic                              mbc1;
   logic                              mbc2;
   logic [cbm_pkg::ROM_BANK_BITS-1:0] bank_mix;

   assign is_wr = (item_data.req_type == cbm_pkg::ACC_WRITE);
   assign addr  = item_data.bus_addr;
   assign data  = item_data.wr_byte;
   assign mbc1  = (cart_kind_ff == cbm_pkg::KIND_MBC1);
   assign mbc2  = (cart_kind_ff == cbm_pkg::KIND_MBC2);

   // Bank register update for MBC1 / MBC2 writes below 0x8000
   always_comb begin
      rom_bank_in = rom_bank_ff;
      ram_bank_in = ram_bank_ff;
      ram_en_in   = ram_en_ff;
      rom_mode_in = rom_mode_ff;
      bank_mix    = rom_bank_ff;
      if (is_wr && !addr[15] && (mbc1 || mbc2)) begin
         unique case (addr[14:13])
            2'd0: begin
               if (!(mbc2 && addr[4])) begin
                  ram_en_in = (data[3:0] == cbm_pkg::RAM_EN_KEY);
               end
            end
            2'd1: begin
               if (mbc2) begin
                  bank_mix = {3'b000, data[3:0]};
               end else begin
                  bank_mix = {rom_bank_ff[6:5], data[4:0]};
               end
               rom_bank_in = (bank_mix == '0) ? 7'd1 : bank_mix;
            end
            2'd2: begin
               if (mbc1) begin
                  if (rom_mode_ff) begin
                     bank_mix    = {data[1:0], rom_bank_ff[4:0]};
                     rom_bank_in = (bank_mix == '0) ? 7'd1 : bank_mix;
                  end else begin
                     ram_bank_in = data[1:0];
                  end
               end
            end
            default: begin
               if (mbc1) begin
                  rom_mode_in = !data[0];
                  if (!data[0]) begin
                     ram_bank_in = '0;
                  end
               end
            end
         endcase
      end
   end

   // Banks step per beat; user: config only while idle (unenforced)
   always_ff @(posedge clock) begin
      if (reset) begin
         cart_kind_ff <= cbm_pkg::KIND_ROM_ONLY;
         rom_bank_ff  <= 7'd1;
         ram_bank_ff  <= '0;
         ram_en_ff    <= 1'b0;
         rom_mode_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            cart_kind_ff <= csr_wdata;
         end
         if (item_take) begin
            rom_bank_ff <= rom_bank_in;
            ram_bank_ff <= ram_bank_in;
            ram_en_ff   <= ram_en_in;
            rom_mode_ff <= rom_mode_in;
         end
      end
   end

   // Address translation
   always_comb begin
      rsp_next.target       = cbm_pkg::TGT_OTHER;
      rsp_next.phys_addr    = {{(cbm_pkg::PHYS_BITS-cbm_pkg::ADDR_BITS){1'b0}}, addr};
      rsp_next.is_store     = is_wr;
      rsp_next.rom_bank_now = rom_bank_in;
      if (!addr[15]) begin
         rsp_next.is_store = 1'b0;
         if (is_wr) begin
            rsp_next.target    = cbm_pkg::TGT_NONE;
            rsp_next.phys_addr = '0;
         end else if (addr[14]) begin
            rsp_next.target    = cbm_pkg::TGT_ROM;
            rsp_next.phys_addr = {rom_bank_ff, addr[cbm_pkg::ROM_OFS_BITS-1:0]};
         end else begin
            rsp_next.target = cbm_pkg::TGT_ROM;
         end
      end else if (addr[15:13] == 3'b101) begin
         if (is_wr && !ram_en_ff) begin
            rsp_next.target    = cbm_pkg::TGT_NONE;
            rsp_next.phys_addr = '0;
            rsp_next.is_store  = 1'b0;
         end else begin
            rsp_next.target    = cbm_pkg::TGT_RAM;
            rsp_next.phys_addr = {
               {(cbm_pkg::PHYS_BITS-cbm_pkg::RAM_BANK_BITS-cbm_pkg::RAM_OFS_BITS){1'b0}},
               ram_bank_ff, addr[cbm_pkg::RAM_OFS_BITS-1:0]};
         end
      end
   end

endmodule

>>> src/cartridge_bank_mapper.sv
// Cartridge bank mapper for MBC1 / MBC2 style cartridges. Each bus access beat
// (read or write, 16-bit address, data byte) yields one result beat: a target
// (none, cartridge ROM, cartridge RAM, other memory), the translated physical
// address, a store flag and the ROM bank selected after the access. Writes
// below 0x8000 update MBC1 / MBC2 bank registers and are absorbed; RAM writes
// while RAM is disabled are dropped. The mapper accepts one beat per clock
// while the result register is free or rsp_ready is high; each beat passes
// through the input register, then the result register. The bank registers
// update once per beat. Write csr_wdata (cart kind: 0 ROM only, 1 MBC1,
// 2 MBC2, 3 acts as ROM only) only while no beats are in flight.
module cartridge_bank_mapper (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cbm_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cbm_pkg::rsp_type      rsp_data
);

   logic                  item_valid;
   logic                  item_take;
   cbm_pkg::req_type_type item_data;
   cbm_pkg::rsp_type      rsp_next;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   cbm_pkg::rsp_type      rsp_data_ff;
   logic                  out_free;

   cbm_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item_data  (item_data)
   );

   cbm_translate u_xlat (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .item_take (item_take),
      .item_data (item_data),
      .rsp_next  (rsp_next)
   );

   // Move the held beat into the result register when it is free
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign item_take = item_valid && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
